FILE: rtl/askbfm_pkg.sv
package askbfm_pkg;

    // Frame layout: start bit, eight data bits LSB first, stop bit.
    localparam int FRAME_BITS = 10;
    localparam int BIT_IDX_W  = 4;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_PHASE_STEP      = 2'd0,
        REG_SAMPLES_PER_BIT = 2'd1,
        REG_HIGH_GAIN       = 2'd2,
        REG_LOW_GAIN        = 2'd3
    } cfg_index_t;

    localparam logic [31:0] PHASE_STEP_RST      = 32'd536822215;
    localparam logic [15:0] SAMPLES_PER_BIT_RST = 16'd800;
    localparam logic [15:0] HIGH_GAIN_RST       = 16'd32768;
    localparam logic [15:0] LOW_GAIN_RST        = 16'd3277;

    // Unity gain in Q1.15; larger settings saturate to it.
    localparam logic [15:0] GAIN_ONE = 16'd32768;

    // Depth of the queue between the sequencer and the sample datapath.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Fixed-point constants used to build the sine ROM.
    localparam longint unsigned TWO_PI_Q40 = 64'd6908435304716;
    localparam longint          PI_Q30     = 64'sd3373259426;
    localparam longint          ONE_Q30    = 64'sd1073741824;

    // Taylor series divisors (2k)(2k+1) for k = 1 to 12.
    localparam longint unsigned TAYLOR_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // Per-request status travelling with each sample.
    typedef struct packed {
        logic last;
        logic active;
        logic taken;
    } flags_t;

endpackage

FILE: rtl/askbfm_front.sv
module askbfm_front #(
    parameter int TABLE_DEPTH = 1024,
    parameter int IDX_W       = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    input  logic                push,
    input  logic                byte_offered,
    input  logic [7:0]          byte_value,
    output logic [IDX_W-1:0]    entry_idx,
    output logic [15:0]         entry_gain,
    output askbfm_pkg::flags_t  entry_flags
);

    localparam int PROD_W = 32 + IDX_W + 1;

    logic [31:0] phase_step_reg;
    logic [15:0] spb_reg;
    logic [15:0] high_gain_reg;
    logic [15:0] low_gain_reg;

    logic [31:0]                      phase_acc_reg, phase_acc_next;
    logic [askbfm_pkg::FRAME_BITS-1:0] frame_reg, frame_next;
    logic [askbfm_pkg::BIT_IDX_W-1:0]  bit_count_reg, bit_count_next;
    logic [15:0]                      sample_count_reg, sample_count_next;
    logic                             busy_reg, busy_next;

    logic                             take;
    logic                             run;
    logic [askbfm_pkg::FRAME_BITS-1:0] frame;
    logic [askbfm_pkg::BIT_IDX_W-1:0]  bit_idx;
    logic [15:0]                      count;
    logic [31:0]                      phase;
    logic [15:0]                      spb;
    logic [15:0]                      gain_raw;
    logic [15:0]                      gain_sat;
    logic [PROD_W-1:0]                idx_prod;
    logic [16:0]                      count_inc;
    logic                             bit_done;
    logic                             frame_done;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= askbfm_pkg::PHASE_STEP_RST;
            spb_reg        <= askbfm_pkg::SAMPLES_PER_BIT_RST;
            high_gain_reg  <= askbfm_pkg::HIGH_GAIN_RST;
            low_gain_reg   <= askbfm_pkg::LOW_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (askbfm_pkg::cfg_index_t'(cfg_index))
                askbfm_pkg::REG_PHASE_STEP:      phase_step_reg <= cfg_wdata;
                askbfm_pkg::REG_SAMPLES_PER_BIT: spb_reg        <= cfg_wdata[15:0];
                askbfm_pkg::REG_HIGH_GAIN:       high_gain_reg  <= cfg_wdata[15:0];
                askbfm_pkg::REG_LOW_GAIN:        low_gain_reg   <= cfg_wdata[15:0];
                default:                         ;
            endcase
        end
    end

    always_comb
    begin
        take  = byte_offered & ~busy_reg;
        run   = busy_reg | take;
        frame = take ? {1'b1, byte_value, 1'b1} : frame_reg;
        bit_idx = take ? '0 : bit_count_reg;
        count   = take ? '0 : sample_count_reg;
        phase   = take ? '0 : phase_acc_reg;
        spb     = (spb_reg == 16'd0) ? 16'd1 : spb_reg;

        gain_raw = frame[bit_idx] ? high_gain_reg : low_gain_reg;
        gain_sat = (gain_raw > askbfm_pkg::GAIN_ONE) ? askbfm_pkg::GAIN_ONE : gain_raw;

        // Table index is the top bits of phase scaled by the table depth.
        idx_prod = PROD_W'(phase) * PROD_W'(TABLE_DEPTH);

        count_inc  = {1'b0, count} + 17'd1;
        bit_done   = count_inc >= {1'b0, spb};
        frame_done = bit_done &&
                     (bit_idx == askbfm_pkg::BIT_IDX_W'(askbfm_pkg::FRAME_BITS - 1));

        phase_acc_next    = phase_acc_reg;
        frame_next        = frame_reg;
        bit_count_next    = bit_count_reg;
        sample_count_next = sample_count_reg;
        busy_next         = busy_reg;

        if (run)
        begin
            phase_acc_next = phase + phase_step_reg;
            frame_next     = frame;
            busy_next      = ~frame_done;
            if (bit_done)
            begin
                sample_count_next = '0;
                bit_count_next    = frame_done ? '0 : bit_idx + 1'b1;
            end
            else
            begin
                sample_count_next = count_inc[15:0];
                bit_count_next    = bit_idx;
            end
        end

        entry_idx          = run ? idx_prod[32 +: IDX_W] : '0;
        entry_gain         = run ? gain_sat : '0;
        entry_flags.taken  = take;
        entry_flags.active = run;
        entry_flags.last   = run & frame_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            frame_reg        <= '0;
            bit_count_reg    <= '0;
            sample_count_reg <= '0;
            busy_reg         <= 1'b0;
        end
        else if (push)
        begin
            phase_acc_reg    <= phase_acc_next;
            frame_reg        <= frame_next;
            bit_count_reg    <= bit_count_next;
            sample_count_reg <= sample_count_next;
            busy_reg         <= busy_next;
        end
    end

endmodule

FILE: rtl/askbfm_queue.sv
module askbfm_queue #(
    parameter int WIDTH = 29
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0]                   mem_reg [askbfm_pkg::QUEUE_DEPTH];
    logic [askbfm_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [askbfm_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [askbfm_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                               push;
    logic                               pop;

    assign in_ready  = count_reg != askbfm_pkg::QUEUE_CNT_W'(askbfm_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/askbfm_back.sv
module askbfm_back #(
    parameter int TABLE_DEPTH = 1024,
    parameter int IDX_W       = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [IDX_W-1:0]    in_idx,
    input  logic [15:0]         in_gain,
    input  askbfm_pkg::flags_t  in_flags,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         out_sample,
    output askbfm_pkg::flags_t  out_flags
);

    // One ROM entry: round(32767 * sin(2*pi*i/TABLE_DEPTH)) from a Q30 Taylor series.
    function automatic logic [15:0] sine_entry(input int unsigned i);
        longint unsigned j;
        longint unsigned ux;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          x;
        longint          sum;
        logic            neg;
        j   = 64'(i);
        neg = 1'b0;
        if (2 * j > 64'(TABLE_DEPTH))
        begin
            j   = 64'(TABLE_DEPTH) - j;
            neg = 1'b1;
        end
        x = longint'((((j * askbfm_pkg::TWO_PI_Q40) / TABLE_DEPTH) + 64'd512) >> 10);
        if (x > askbfm_pkg::PI_Q30 / 2)
        begin
            x = askbfm_pkg::PI_Q30 - x;
        end
        if (x < 0)
        begin
            x = 0;
        end
        ux   = 64'(x);
        x2   = (ux * ux) >> 30;
        term = ux;
        sum  = x;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * x2) >> 30) / askbfm_pkg::TAYLOR_DIV[k];
            if (k % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > askbfm_pkg::ONE_Q30)
        begin
            sum = askbfm_pkg::ONE_Q30;
        end
        v = ((64'(sum) * 64'd32767) + 64'd536870912) >> 30;
        return neg ? 16'(64'd0 - v) : 16'(v);
    endfunction

    logic [15:0] sine_rom [TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_rom
        assign sine_rom[g] = sine_entry(g);
    end

    // Stage 1: registered ROM read.
    logic               s1_valid_reg;
    logic [15:0]        s1_sine_reg;
    logic [15:0]        s1_gain_reg;
    askbfm_pkg::flags_t s1_flags_reg;

    // Stage 2: gain multiply into the output register.
    logic               out_valid_reg;
    logic [15:0]        out_sample_reg, out_sample_next;
    askbfm_pkg::flags_t out_flags_reg;

    logic        s2_load;
    logic        s1_load;
    logic [15:0] sine_abs;
    logic [30:0] mag_prod;
    logic [15:0] mag;

    assign s2_load  = ~out_valid_reg | out_ready;
    assign s1_load  = ~s1_valid_reg | s2_load;
    assign in_ready = s1_load;

    always_comb
    begin
        sine_abs = s1_sine_reg[15] ? 16'd0 - s1_sine_reg : s1_sine_reg;
        mag_prod = 31'(sine_abs[14:0]) * 31'(s1_gain_reg);
        mag      = mag_prod[30:15];
        out_sample_next = s1_sine_reg[15] ? 16'd0 - mag : mag;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_sine_reg  <= sine_rom[in_idx];
            s1_gain_reg  <= in_gain;
            s1_flags_reg <= in_flags;
        end
        if (s2_load && s1_valid_reg)
        begin
            out_sample_reg <= out_sample_next;
            out_flags_reg  <= s1_flags_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_flags  = out_flags_reg;

endmodule

FILE: rtl/ask_byte_frame_modulator_unit.sv
// Amplitude shift keying modulator for one framed byte at a time.
// Every request on the slave stream is one sample tick. s_axis_tuser says whether
// a byte is offered on that tick and s_axis_tdata carries the byte. When no frame
// is running an offered byte is taken and a ten-bit frame (start one, eight data
// bits LSB first, stop one) is sent, each bit lasting samples_per_bit ticks.
// Every request produces exactly one request on the master stream: a signed
// sine-carrier sample scaled by the high or low gain, or silence while idle.
// Throughput is one request per cycle in each direction while m_axis_tready stays
// high. An accepted input request passes into the queue, then through the
// registered sine ROM read and the gain multiply into the output register. The
// sequencer accepts requests while the four-entry queue has room,
// so a stalled receiver is absorbed by the queue and the two pipeline registers
// before s_axis_tready falls. Reset empties the queue and the pipeline, stops
// any frame, clears the carrier phase and reloads the register defaults.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata
// and should only be changed while no frame is being sent.
module ask_byte_frame_modulator_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // Sample tick requests in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tuser,   // [0] byte_offered
    // Sample requests out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample (signed)
    output logic [1:0]  m_axis_tuser,   // [0] byte_taken, [1] frame_active
    output logic        m_axis_tlast    // frame_last
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int FLAGS_W = $bits(askbfm_pkg::flags_t);
    localparam int ENTRY_W = IDX_W + 16 + FLAGS_W;

    logic                q_in_ready;
    logic                push;
    logic [IDX_W-1:0]    entry_idx;
    logic [15:0]         entry_gain;
    askbfm_pkg::flags_t  entry_flags;

    logic                q_out_valid;
    logic                q_out_ready;
    logic [ENTRY_W-1:0]  q_out_data;

    logic [15:0]         out_sample;
    askbfm_pkg::flags_t  out_flags;

    // A tick is sequenced only when the queue can hold its entry.
    assign s_axis_tready = q_in_ready;
    assign push          = s_axis_tvalid & q_in_ready;

    askbfm_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .byte_offered (s_axis_tuser),
        .byte_value   (s_axis_tdata),
        .entry_idx    (entry_idx),
        .entry_gain   (entry_gain),
        .entry_flags  (entry_flags)
    );

    askbfm_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (q_in_ready),
        .in_data   ({entry_flags, entry_gain, entry_idx}),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    askbfm_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_out_valid),
        .in_ready   (q_out_ready),
        .in_idx     (q_out_data[IDX_W-1:0]),
        .in_gain    (q_out_data[IDX_W +: 16]),
        .in_flags   (askbfm_pkg::flags_t'(q_out_data[IDX_W + 16 +: FLAGS_W])),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (out_sample),
        .out_flags  (out_flags)
    );

    assign m_axis_tdata    = out_sample;
    assign m_axis_tuser[0] = out_flags.taken;
    assign m_axis_tuser[1] = out_flags.active;
    assign m_axis_tlast    = out_flags.last;

endmodule

FILE: rtl/askbfm_checker.sv
module askbfm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // The last sample of a frame is always a frame sample.
    a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
        else $error("frame_last without frame_active");

    // A taken byte starts a frame on the same sample.
    a_taken_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("byte_taken without frame_active");

    // Idle samples are silent.
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata == 16'd0)
        else $error("non-zero sample while idle");

    // The scaled carrier never reaches the most negative code.
    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata != 16'h8000)
        else $error("sample out of range");

    // A stalled output request holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

endmodule

bind ask_byte_frame_modulator_unit askbfm_checker u_askbfm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
